@@ rtl/tddr_pkg.sv @@
package tddr_pkg;

	localparam int COORD_W   = 16;
	localparam int TIMER_W   = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DT_W      = 10;
	localparam int OP_W      = 3;
	localparam int KIND_W    = 3;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [CFG_W-1:0] HOLD_RESET   = CFG_W'(200);
	localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(250);

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HOLD   = 2'd0,
		REG_WINDOW = 2'd1
	} reg_idx_t;

	typedef enum logic [OP_W-1:0] {
		OP_PRESS   = 3'd0,
		OP_MOVE    = 3'd1,
		OP_RELEASE = 3'd2,
		OP_CANCEL  = 3'd3,
		OP_TICK    = 3'd4
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		EV_ACCEPTED  = 3'd0,
		EV_REJECTED  = 3'd1,
		EV_DRAG      = 3'd2,
		EV_CLICK     = 3'd3,
		EV_DOUBLE    = 3'd4,
		EV_ENDED     = 3'd5,
		EV_CANCELLED = 3'd6
	} kind_t;

	typedef enum logic [3:0] {
		MODE_IDLE     = 4'b0001,
		MODE_PRESSED  = 4'b0010,
		MODE_DRAGGING = 4'b0100,
		MODE_CLICKED  = 4'b1000
	} mode_t;

	// dbl: double click, expands to a double click result and an ended result
	typedef struct packed {
		kind_t  kind;
		logic   dbl;
		coord_t fx;
		coord_t fy;
		coord_t tx;
		coord_t ty;
	} res_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

@@ rtl/tddr_in_if.sv @@
interface tddr_in_if
	import tddr_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic              hit;
	coord_t            pos_x;
	coord_t            pos_y;
	logic [DT_W-1:0]   elapsed_ms;

	modport source (output valid, opcode, hit, pos_x, pos_y, elapsed_ms, input ready);
	modport sink (input valid, opcode, hit, pos_x, pos_y, elapsed_ms, output ready);
endinterface

@@ rtl/tddr_out_if.sv @@
interface tddr_out_if
	import tddr_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] event_kind;
	coord_t            from_x;
	coord_t            from_y;
	coord_t            to_x;
	coord_t            to_y;
	logic              last;

	modport source (output valid, event_kind, from_x, from_y, to_x, to_y, last, input ready);
	modport sink (input valid, event_kind, from_x, from_y, to_x, to_y, last, output ready);
endinterface

@@ rtl/tddr_cfg_if.sv @@
interface tddr_cfg_if
	import tddr_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/tddr_front.sv @@
module tddr_front
	import tddr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tddr_in_if.sink     ev_in,
	tddr_cfg_if.sink    cfg,
	input  q_stat_t     qs,
	output logic        push,
	output res_entry_t  push_data
);

	logic [CFG_W-1:0]   hold_q, window_q;
	mode_t              mode_q, mode_d;
	logic               timing_q, timing_d;
	logic [TIMER_W-1:0] timer_q, timer_d;
	coord_t             prev_x_q, prev_y_q, rel_x_q, rel_y_q;
	logic               set_prev, set_rel;
	logic               emit;
	res_entry_t         ent;
	logic [TIMER_W:0]   tsum;
	logic [TIMER_W-1:0] tsat;
	logic               acc;

	assign cfg.ready   = 1'b1;
	assign ev_in.ready = !qs.full;
	assign acc         = ev_in.valid && ev_in.ready;

	assign tsum = {1'b0, timer_q} + (TIMER_W+1)'(ev_in.elapsed_ms);
	assign tsat = tsum[TIMER_W] ? {TIMER_W{1'b1}} : tsum[TIMER_W-1:0];

	always_comb begin
		mode_d   = mode_q;
		timing_d = timing_q;
		timer_d  = timer_q;
		set_prev = 1'b0;
		set_rel  = 1'b0;
		emit     = 1'b0;
		ent      = '{kind: EV_ENDED, dbl: 1'b0, fx: '0, fy: '0,
			tx: ev_in.pos_x, ty: ev_in.pos_y};
		unique case (ev_in.opcode)
			OP_PRESS: begin
				emit = 1'b1;
				if (ev_in.hit) begin
					ent.kind = EV_ACCEPTED;
					if (mode_q == MODE_IDLE)
						mode_d = MODE_PRESSED;
					timing_d = 1'b1;
					timer_d  = '0;
					set_prev = 1'b1;
				end else begin
					ent.kind = EV_REJECTED;
				end
			end
			OP_MOVE: begin
				if (mode_q == MODE_DRAGGING) begin
					emit     = 1'b1;
					ent.kind = EV_DRAG;
					ent.fx   = prev_x_q;
					ent.fy   = prev_y_q;
					set_prev = 1'b1;
				end else if (timing_q && (timer_q > TIMER_W'(hold_q))) begin
					mode_d   = MODE_DRAGGING;
					timing_d = 1'b0;
					timer_d  = '0;
				end
			end
			OP_RELEASE: begin
				emit = 1'b1;
				if (mode_q == MODE_PRESSED) begin
					mode_d   = MODE_CLICKED;
					timing_d = 1'b1;
					timer_d  = '0;
					set_rel  = 1'b1;
				end else begin
					mode_d   = MODE_IDLE;
					timing_d = 1'b0;
					timer_d  = '0;
					if (mode_q == MODE_CLICKED) begin
						ent.kind = EV_DOUBLE;
						ent.dbl  = 1'b1;
						ent.fx   = ev_in.pos_x;
						ent.fy   = ev_in.pos_y;
					end
				end
			end
			OP_CANCEL: begin
				emit     = 1'b1;
				ent.kind = EV_CANCELLED;
				mode_d   = MODE_IDLE;
				timing_d = 1'b0;
				timer_d  = '0;
			end
			OP_TICK: begin
				if (timing_q) begin
					timer_d = tsat;
					if (mode_q == MODE_CLICKED && (tsat > TIMER_W'(window_q))) begin
						emit     = 1'b1;
						ent.kind = EV_CLICK;
						ent.fx   = rel_x_q;
						ent.fy   = rel_y_q;
						ent.tx   = '0;
						ent.ty   = '0;
						mode_d   = MODE_IDLE;
						timing_d = 1'b0;
						timer_d  = '0;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign push      = acc && emit;
	assign push_data = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q   <= HOLD_RESET;
			window_q <= WINDOW_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_HOLD:   hold_q   <= cfg.data;
				REG_WINDOW: window_q <= cfg.data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			timing_q <= 1'b0;
			timer_q  <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			rel_x_q  <= '0;
			rel_y_q  <= '0;
		end else if (acc) begin
			mode_q   <= mode_d;
			timing_q <= timing_d;
			timer_q  <= timer_d;
			if (set_prev) begin
				prev_x_q <= ev_in.pos_x;
				prev_y_q <= ev_in.pos_y;
			end
			if (set_rel) begin
				rel_x_q <= ev_in.pos_x;
				rel_y_q <= ev_in.pos_y;
			end
		end
	end

endmodule

@@ rtl/tddr_queue.sv @@
module tddr_queue
	import tddr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  res_entry_t push_data,
	input  logic       pop,
	output res_entry_t head,
	output q_stat_t    qs
);

	res_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign qs.empty = (cnt_q == '0);
	assign qs.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

@@ rtl/tddr_back.sv @@
module tddr_back
	import tddr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  res_entry_t head,
	input  q_stat_t    qs,
	output logic       pop,
	tddr_out_if.source res_out
);

	logic   valid_q;
	logic   beat_q;
	logic   load;
	kind_t  kind_q;
	coord_t fx_q, fy_q, tx_q, ty_q;
	logic   last_q;

	assign load = !qs.empty && (!valid_q || res_out.ready);
	assign pop  = load && (!head.dbl || beat_q);

	assign res_out.valid      = valid_q;
	assign res_out.event_kind = kind_q;
	assign res_out.from_x     = fx_q;
	assign res_out.from_y     = fy_q;
	assign res_out.to_x       = tx_q;
	assign res_out.to_y       = ty_q;
	assign res_out.last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				beat_q  <= head.dbl && !beat_q;
			end else if (res_out.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tx_q <= head.tx;
			ty_q <= head.ty;
			if (head.dbl && beat_q) begin
				kind_q <= EV_ENDED;
				fx_q   <= '0;
				fy_q   <= '0;
				last_q <= 1'b1;
			end else begin
				kind_q <= head.kind;
				fx_q   <= head.fx;
				fy_q   <= head.fy;
				last_q <= !head.dbl;
			end
		end
	end

endmodule

@@ rtl/tap_double_tap_drag_recognizer.sv @@
// Tap, double-tap and drag recognizer. Accepts one touch event or time tick per
// cycle on ev_in; the event is classified and the gesture state updated in the
// cycle of its transfer, and its results go into a four-entry result queue. The
// output side delivers one result per cycle from a registered stage while
// res_out.ready is high, so a release that completes a double click puts its two
// results on the output in turn; ev_in.ready drops only while the queue is full.
// An input's first result passes the queue entry, then the output register.
// Registers (index 0 hold time, index 1 double-click window) must be written on cfg
// only while the block is idle; the block does not enforce this. cfg.ready is
// always high. No clearing pass follows reset.
module tap_double_tap_drag_recognizer
	import tddr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	tddr_in_if.sink    ev_in,
	tddr_cfg_if.sink   cfg,
	tddr_out_if.source res_out
);

	logic       push, pop;
	res_entry_t push_data, head;
	q_stat_t    qs;

	tddr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_in     (ev_in),
		.cfg       (cfg),
		.qs        (qs),
		.push      (push),
		.push_data (push_data)
	);

	tddr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qs        (qs)
	);

	tddr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qs      (qs),
		.pop     (pop),
		.res_out (res_out)
	);

endmodule

@@ rtl/tddr_checker.sv @@
module tddr_checker
	import tddr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [KIND_W-1:0] out_kind,
	input coord_t            out_to_x,
	input coord_t            out_to_y,
	input logic              out_last
);

	// hold a stalled result
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_kind_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_kind) && $stable(out_to_x))
		else $error("stalled result changed");

	a_double_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == EV_DOUBLE |-> !out_last)
		else $error("double click marked last");

	// a double click transfer is followed at once by its ended result
	a_double_then_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_kind == EV_DOUBLE |=>
			out_valid && out_kind == EV_ENDED && out_last &&
			out_to_x == $past(out_to_x) && out_to_y == $past(out_to_y))
		else $error("double click not followed by ended");

	a_click_to_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == EV_CLICK |-> out_to_x == '0 && out_to_y == '0 && out_last)
		else $error("click result malformed");

endmodule

bind tap_double_tap_drag_recognizer tddr_checker u_tddr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (res_out.valid),
	.out_ready (res_out.ready),
	.out_kind  (res_out.event_kind),
	.out_to_x  (res_out.to_x),
	.out_to_y  (res_out.to_y),
	.out_last  (res_out.last)
);
